// ===== rtl/apl_pkg.sv =====
package apl_pkg;

  // Default number of entries the list can hold.
  localparam int CAPACITY_DEF = 128;

  // Fixed widths of the stream fields.
  localparam int CMD_W    = 4;
  localparam int POS_W    = 7;
  localparam int CODE_W   = 32;
  localparam int YEAR_W   = 16;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 8;
  localparam int IN_W     = 72;
  localparam int OUT_W    = 64;

  // Fan-in of one level of the read gather tree.
  localparam int GATHER_FANIN = 8;

  // One stored list entry.
  typedef struct packed {
    logic signed [CODE_W-1:0] code;
    logic        [YEAR_W-1:0] year;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Command codes of the input stream.
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 4'd0,
    CMD_INS_AT   = 4'd1,
    CMD_INS_TAIL = 4'd2,
    CMD_SWAP     = 4'd3,
    CMD_EDIT     = 4'd4,
    CMD_RM_HEAD  = 4'd5,
    CMD_RM_TAIL  = 4'd6,
    CMD_RM_AT    = 4'd7,
    CMD_READ     = 4'd8
  } cmd_t;

  // Status codes of the result stream.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_BADPOS = 3'd3,
    ST_SAME   = 3'd4
  } status_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_WRITE  = 3'd3,
    OP_SWAP   = 3'd4
  } cell_op_t;

  // Control and write data shared by all cells.
  typedef struct packed {
    cell_op_t op;
    entry_t   wr_at;
    entry_t   wr_other;
  } cell_cmd_t;

  // Number of registered levels needed to gather n leaves at GATHER_FANIN each.
  function automatic int apl_levels(input int n);
    int lv;
    int span;
    lv   = 1;
    span = GATHER_FANIN;
    while (span < n) begin
      lv   = lv + 1;
      span = span * GATHER_FANIN;
    end
    return lv;
  endfunction

  // Number of nodes in gather level l of a tree with the given depth.
  function automatic int apl_level_size(input int levels, input int l);
    int sz;
    sz = 1;
    for (int k = 0; k < levels - 1 - l; k++) begin
      sz = sz * GATHER_FANIN;
    end
    return sz;
  endfunction

  // Offset of gather level l in the flat node array.
  function automatic int apl_level_base(input int levels, input int l);
    int base;
    base = 0;
    for (int k = 0; k < l; k++) begin
      base = base + apl_level_size(levels, k);
    end
    return base;
  endfunction

endpackage

// ===== rtl/positional_array_list_core.sv =====
// Positional array list core: an ordered list of up to CAPACITY entries,
// each a signed 32-bit code and a 16-bit year, kept in a row of cells.
// The input stream carries one command per transfer (insert at head,
// position or tail; swap; edit; remove at head, tail or position; read).
// The output stream returns one result per command: a status, the entry
// count after the command and the removed or read entry (zero otherwise).
// The read tree over the cells is 8-way, registered and LEVELS deep
// (3 levels for 128 entries); each command reads through it before the
// list is updated, and no new command is accepted until the previous one
// has been applied. All shifts of the list happen in parallel.
// The output register lets a new command be accepted while a result
// waits; if the receiver stalls, the next command finishes its read and
// then waits until the output register is free before updating the list.
// Reset (synchronous, active low) empties the list and clears both
// channels; stored entry contents are not cleared.
module positional_array_list_core
  import apl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // command[3:0], position[10:4], other_position[17:11],
  // entry_code[49:18], entry_year[65:50], zero fill above
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // status[2:0], entry_count[10:3], result_code[42:11],
  // result_year[58:43], zero fill above
  output logic [OUT_W-1:0] out_tdata
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int IW     = (CW > POS_W) ? CW : POS_W;
  localparam int LEVELS = apl_levels(CAPACITY);
  localparam int WW     = $clog2(LEVELS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_APPLY
  } state_t;

  state_t              state_r;
  logic [WW-1:0]       wait_r;
  logic [CW-1:0]       count_r;
  logic                out_tvalid_r;
  logic [OUT_W-1:0]    out_data_r;

  // Latched command decisions.
  cell_op_t            op_r;
  status_t             status_r;
  logic [IW-1:0]       at_r;
  logic [IW-1:0]       other_r;
  logic [CW-1:0]       count_nxt_r;
  logic                rd_r;
  entry_t              new_r;

  // Decode outputs.
  cmd_t                cmd_in;
  logic [IW-1:0]       cnt_x;
  logic [IW-1:0]       pos_x;
  logic [IW-1:0]       pos2_x;
  cell_op_t            op_nxt;
  status_t             status_nxt;
  logic [IW-1:0]       at_nxt;
  logic [CW-1:0]       count_nxt;
  logic                rd_nxt;
  entry_t              new_in;

  logic                accept;
  logic                fire;
  cell_cmd_t           cell_cmd;
  entry_t              entry_w [CAPACITY];
  entry_t              sel_a_w [CAPACITY];
  entry_t              sel_b_w [CAPACITY];
  entry_t              root_a;
  entry_t              root_b;
  entry_t              res;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign fire      = (state_r == S_APPLY) && (!out_tvalid_r || out_tready);

  assign cmd_in      = cmd_t'(in_tdata[3:0]);
  assign pos_x       = IW'(in_tdata[10:4]);
  assign pos2_x      = IW'(in_tdata[17:11]);
  assign new_in.code = in_tdata[49:18];
  assign new_in.year = in_tdata[65:50];
  assign cnt_x       = IW'(count_r);

  // Command decode against the current count.
  always_comb begin
    status_nxt = ST_OK;
    op_nxt     = OP_HOLD;
    at_nxt     = pos_x;
    count_nxt  = count_r;
    rd_nxt     = 1'b0;
    unique case (cmd_in) inside
      [CMD_INS_HEAD:CMD_INS_TAIL]: begin
        if (count_r == CW'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else if (cmd_in == CMD_INS_AT && pos_x > cnt_x) begin
          status_nxt = ST_BADPOS;
        end else begin
          op_nxt    = OP_INSERT;
          count_nxt = count_r + CW'(1);
          if (cmd_in == CMD_INS_HEAD) begin
            at_nxt = '0;
          end else if (cmd_in == CMD_INS_TAIL) begin
            at_nxt = cnt_x;
          end
        end
      end
      CMD_SWAP: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (pos_x >= cnt_x || pos2_x >= cnt_x) begin
          status_nxt = ST_BADPOS;
        end else if (pos_x == pos2_x) begin
          status_nxt = ST_SAME;
        end else begin
          op_nxt = OP_SWAP;
        end
      end
      CMD_EDIT, CMD_READ: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status_nxt = ST_BADPOS;
        end else if (cmd_in == CMD_EDIT) begin
          op_nxt = OP_WRITE;
        end else begin
          rd_nxt = 1'b1;
        end
      end
      [CMD_RM_HEAD:CMD_RM_AT]: begin
        if (cmd_in == CMD_RM_HEAD) begin
          at_nxt = '0;
        end else if (cmd_in == CMD_RM_TAIL) begin
          at_nxt = cnt_x - IW'(1);
        end
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (at_nxt >= cnt_x) begin
          status_nxt = ST_BADPOS;
        end else begin
          op_nxt    = OP_REMOVE;
          rd_nxt    = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Command payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r        <= op_nxt;
      status_r    <= status_nxt;
      at_r        <= at_nxt;
      other_r     <= pos2_x;
      count_nxt_r <= count_nxt;
      rd_r        <= rd_nxt;
      new_r       <= new_in;
    end
  end

  // Broadcast to the cells: only in the apply cycle does anything move.
  always_comb begin
    cell_cmd.op       = fire ? op_r : OP_HOLD;
    cell_cmd.wr_at    = (op_r == OP_SWAP) ? root_b : new_r;
    cell_cmd.wr_other = root_a;
  end

  // The chain of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    assign prev_e = (i == 0) ? entry_w[i] : entry_w[(i == 0) ? 0 : i - 1];
    assign next_e = (i == CAPACITY - 1) ? entry_w[i]
                                        : entry_w[(i == CAPACITY - 1) ? i : i + 1];
    apl_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .at         (at_r),
      .other      (other_r),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry      (entry_w[i]),
      .sel_a      (sel_a_w[i]),
      .sel_b      (sel_b_w[i])
    );
  end

  // Read trees for the two addressed positions.
  apl_gather #(
    .N (CAPACITY)
  ) u_gather_a (
    .clk  (clk),
    .leaf (sel_a_w),
    .root (root_a)
  );

  apl_gather #(
    .N (CAPACITY)
  ) u_gather_b (
    .clk  (clk),
    .leaf (sel_b_w),
    .root (root_b)
  );

  assign res = rd_r ? root_a : '0;

  // Sequencer, count and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wait_r       <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
      out_data_r   <= '0;
    end else begin
      // An apply loads a result; otherwise a taken result empties the register.
      if (fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            wait_r  <= WW'(LEVELS);
            state_r <= S_GATHER;
          end
        end
        S_GATHER: begin
          wait_r <= wait_r - WW'(1);
          if (wait_r == WW'(1)) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (fire) begin
            count_r      <= count_nxt_r;
            out_data_r   <= OUT_W'({res.year, res.code, COUNT_W'(count_nxt_r), status_r});
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // The count only moves in a completed apply cycle.
  a_count_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> $past(fire))
    else $error("entry count changed outside apply");

  // A new result appears only from an apply cycle.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(fire))
    else $error("result without apply");

  // An empty status always reports an empty list.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_data_r[2:0] == ST_EMPTY) |-> (out_data_r[10:3] == '0))
    else $error("empty status with nonzero count");

  // No input is taken while a command is in flight.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GATHER || state_r == S_APPLY) |-> !in_tready)
    else $error("input accepted during command");
`endif

endmodule

// ===== rtl/apl_cell.sv =====
module apl_cell
  import apl_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 8
) (
  input  logic          clk,
  input  cell_cmd_t     cmd,
  input  logic [IW-1:0] at,
  input  logic [IW-1:0] other,
  input  entry_t        prev_entry,
  input  entry_t        next_entry,
  output entry_t        entry,
  output entry_t        sel_a,
  output entry_t        sel_b
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  entry_t entry_r;

  // Each cell decides locally whether to shift, load or hold.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_INSERT: begin
        if (MY_IDX > at) begin
          entry_r <= prev_entry;
        end else if (MY_IDX == at) begin
          entry_r <= cmd.wr_at;
        end
      end
      OP_REMOVE: begin
        if (MY_IDX >= at) begin
          entry_r <= next_entry;
        end
      end
      OP_WRITE: begin
        if (MY_IDX == at) begin
          entry_r <= cmd.wr_at;
        end
      end
      OP_SWAP: begin
        if (MY_IDX == at) begin
          entry_r <= cmd.wr_at;
        end else if (MY_IDX == other) begin
          entry_r <= cmd.wr_other;
        end
      end
      default: begin
        entry_r <= entry_r;
      end
    endcase
  end

  // Gated outputs feed the two read gather trees.
  assign entry = entry_r;
  assign sel_a = (MY_IDX == at)    ? entry_r : '0;
  assign sel_b = (MY_IDX == other) ? entry_r : '0;

endmodule

// ===== rtl/apl_gather.sv =====
module apl_gather
  import apl_pkg::*;
#(
  parameter int N = CAPACITY_DEF
) (
  input  logic   clk,
  input  entry_t leaf [N],
  output entry_t root
);

  localparam int LEVELS = apl_levels(N);
  localparam int LEAVES = apl_level_size(LEVELS + 1, 0);
  localparam int TOTAL  = apl_level_base(LEVELS, LEVELS);

  entry_t pad     [LEAVES];
  entry_t node_r  [TOTAL];

  // Unused leaves read as zero so they do not disturb the OR.
  for (genvar i = 0; i < LEAVES; i++) begin : g_pad
    if (i < N) begin : g_leaf
      assign pad[i] = leaf[i];
    end else begin : g_zero
      assign pad[i] = '0;
    end
  end

  // Registered OR tree: at most one leaf per tree is nonzero.
  for (genvar lv = 0; lv < LEVELS; lv++) begin : g_lvl
    localparam int SIZE = apl_level_size(LEVELS, lv);
    localparam int BASE = apl_level_base(LEVELS, lv);
    localparam int PREV = (lv == 0) ? 0 : apl_level_base(LEVELS, lv - 1);
    for (genvar n = 0; n < SIZE; n++) begin : g_node
      entry_t acc;
      if (lv == 0) begin : g_first
        always_comb begin
          acc = '0;
          for (int k = 0; k < GATHER_FANIN; k++) begin
            acc = acc | pad[n*GATHER_FANIN + k];
          end
        end
      end else begin : g_upper
        always_comb begin
          acc = '0;
          for (int k = 0; k < GATHER_FANIN; k++) begin
            acc = acc | node_r[PREV + n*GATHER_FANIN + k];
          end
        end
      end
      always_ff @(posedge clk) begin
        node_r[BASE + n] <= acc;
      end
    end
  end

  assign root = node_r[TOTAL-1];

endmodule

// ===== bench/list_check_pkg.sv =====
`timescale 1ns / 100ps

package list_check_pkg;
  import apl_pkg::*;

  // Fields of one result transfer.
  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   count;
    entry_t               item;
  } reply_t;

  // Mirror of the list contents. Every accepted command updates the mirror and
  // queues the reply that the core must give for it.
  class list_shadow;
    entry_t     slots [CAPACITY_DEF];
    int         fill = 0;
    reply_t     replies_due [$];
    int         mismatches = 0;
    int         replies_seen = 0;

    function void apply_command(logic [IN_W-1:0] word);
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] pos2;
      entry_t           fresh;
      entry_t           tmp;
      reply_t           r;
      int               at;
      cmd        = word[3:0];
      pos        = word[10:4];
      pos2       = word[17:11];
      fresh.code = word[49:18];
      fresh.year = word[65:50];
      r.status   = ST_OK;
      r.item     = '0;
      case (cmd)
        CMD_INS_HEAD, CMD_INS_AT, CMD_INS_TAIL: begin
          // A full list is reported before a bad position.
          if (fill >= CAPACITY_DEF) begin
            r.status = ST_FULL;
          end else begin
            if (cmd == CMD_INS_HEAD) at = 0;
            else if (cmd == CMD_INS_TAIL) at = fill;
            else at = int'(pos);
            if (at > fill) begin
              r.status = ST_BADPOS;
            end else begin
              for (int i = fill; i > at; i--) slots[i] = slots[i - 1];
              slots[at] = fresh;
              fill++;
            end
          end
        end
        CMD_SWAP: begin
          if (fill == 0) r.status = ST_EMPTY;
          else if (int'(pos) >= fill || int'(pos2) >= fill) r.status = ST_BADPOS;
          else if (pos == pos2) r.status = ST_SAME;
          else begin
            tmp         = slots[pos];
            slots[pos]  = slots[pos2];
            slots[pos2] = tmp;
          end
        end
        CMD_EDIT: begin
          if (fill == 0) r.status = ST_EMPTY;
          else if (int'(pos) >= fill) r.status = ST_BADPOS;
          else slots[pos] = fresh;
        end
        CMD_RM_HEAD, CMD_RM_TAIL, CMD_RM_AT: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            if (cmd == CMD_RM_HEAD) at = 0;
            else if (cmd == CMD_RM_TAIL) at = fill - 1;
            else at = int'(pos);
            if (at >= fill) begin
              r.status = ST_BADPOS;
            end else begin
              r.item = slots[at];
              for (int i = at; i + 1 < fill; i++) slots[i] = slots[i + 1];
              fill--;
            end
          end
        end
        CMD_READ: begin
          if (fill == 0) r.status = ST_EMPTY;
          else if (int'(pos) >= fill) r.status = ST_BADPOS;
          else r.item = slots[pos];
        end
        // Spare command codes leave the list alone.
        default: begin
        end
      endcase
      r.count = COUNT_W'(fill);
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [OUT_W-1:0] word);
      reply_t got;
      reply_t want;
      got.status    = status_t'(word[2:0]);
      got.count     = word[10:3];
      got.item.code = word[42:11];
      got.item.year = word[58:43];
      replies_seen++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with no command outstanding", replies_seen);
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status || got.count !== want.count ||
          got.item.code !== want.item.code || got.item.year !== want.item.year) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d: expected status %0d count %0d code %0d year %0d",
                   replies_seen, want.status, want.count, want.item.code, want.item.year);
          $display("result %0d: got      status %0d count %0d code %0d year %0d",
                   replies_seen, got.status, got.count, got.item.code, got.item.year);
        end
      end
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import apl_pkg::*;
  import list_check_pkg::*;

  localparam int        CYCLE_LIMIT   = 200000;
  localparam int        RANDOM_ITEMS  = 480;
  localparam int        LONG_HOLD     = 80;
  localparam int        HOLD_AT_REPLY = 150;
  localparam int        SETTLE_CYCLES = 16;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd9;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

  // Command mix of the random part.
  typedef enum { MIX_BALANCED, MIX_GROW, MIX_SHRINK } mix_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  list_shadow shadow = new;
  int         cycles = 0;
  bit         send_quiet = 0;
  bit         recv_quiet = 0;

  positional_array_list_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Transfers on both channels feed the list mirror.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) shadow.apply_command(in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.check_reply(out_tdata);
  end

  // Result side: random stalls, quiet stretches and one long hold-off.
  initial begin : receiver
    int gap;
    int taken;
    taken = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_quiet = !recv_quiet;
      gap = recv_quiet ? 0 : $urandom_range(0, 8);
      if (taken == HOLD_AT_REPLY) gap = LONG_HOLD;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  // Offers one command and returns at the edge where it transfers.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input int pos, input int pos2,
                              input logic [CODE_W-1:0] code, input logic [YEAR_W-1:0] year);
    int gap;
    if ($urandom_range(0, 15) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {6'd0, year, code, POS_W'(pos2), POS_W'(pos), cmd};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Sender pauses until every outstanding result has come back.
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [CMD_W-1:0] pick_command(input mix_t mix);
    int ins_w;
    int rm_w;
    int roll;
    logic [CMD_W-1:0] c;
    case (mix)
      MIX_GROW: begin
        ins_w = 75;
        rm_w  = 8;
      end
      MIX_SHRINK: begin
        ins_w = 8;
        rm_w  = 78;
      end
      default: begin
        ins_w = 35;
        rm_w  = 30;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_w) begin
      case ($urandom_range(0, 2))
        0: c = CMD_INS_HEAD;
        1: c = CMD_INS_AT;
        default: c = CMD_INS_TAIL;
      endcase
    end else if (roll < ins_w + rm_w) begin
      case ($urandom_range(0, 2))
        0: c = CMD_RM_HEAD;
        1: c = CMD_RM_AT;
        default: c = CMD_RM_TAIL;
      endcase
    end else if (roll < 97) begin
      case ($urandom_range(0, 2))
        0: c = CMD_SWAP;
        1: c = CMD_EDIT;
        default: c = CMD_READ;
      endcase
    end else begin
      c = CMD_SPARE_LO + CMD_W'($urandom_range(0, CMD_SPARE_HI - CMD_SPARE_LO));
    end
    return c;
  endfunction

  // Mostly a position inside the list; sometimes the boundary or anything at all.
  function automatic int pick_position(input logic [CMD_W-1:0] cmd, input int fill);
    int roll;
    int top;
    roll = $urandom_range(0, 9);
    top  = (cmd == CMD_INS_AT) ? fill : fill - 1;
    if (top > 127) top = 127;
    if (roll == 0) return $urandom_range(0, 127);
    if (roll == 1) return (fill > 127) ? 127 : fill;
    if (top < 0) return 0;
    return $urandom_range(0, top);
  endfunction

  initial begin : stimulus
    mix_t             mix;
    logic [CMD_W-1:0] cmd;
    int               pos;
    int               pos2;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every read, swap, edit and remove command on the empty list.
    send_command(CMD_READ,    0, 0, '0, '0);
    send_command(CMD_SWAP,    0, 0, '0, '0);
    send_command(CMD_EDIT,    0, 0, 32'h1234_5678, 16'h00ff);
    send_command(CMD_RM_HEAD, 0, 0, '0, '0);
    send_command(CMD_RM_TAIL, 0, 0, '0, '0);
    send_command(CMD_RM_AT,   0, 0, '0, '0);
    // Insert past the count is refused; at the count it appends.
    send_command(CMD_INS_AT,   1, 0, 32'h0000_0001, 16'h0001);
    send_command(CMD_INS_AT,   0, 0, 32'h8000_0000, 16'h0000);
    send_command(CMD_INS_HEAD, 0, 0, 32'h7fff_ffff, 16'hffff);
    send_command(CMD_INS_TAIL, 0, 0, 32'hffff_ffff, 16'h1234);
    send_command(CMD_INS_AT,   3, 0, 32'h0000_0000, 16'h7fff);
    send_command(CMD_INS_AT,   5, 0, 32'h0000_0005, 16'h0005);
    // Reads, swaps and edits on a list of four.
    send_command(CMD_READ, 127, 0, '0, '0);
    send_command(CMD_READ,   0, 0, '0, '0);
    send_command(CMD_SWAP,   1, 1, '0, '0);
    send_command(CMD_SWAP,   0, 4, '0, '0);
    send_command(CMD_SWAP,   0, 3, '0, '0);
    send_command(CMD_EDIT,   4, 0, 32'hdead_beef, 16'hbeef);
    send_command(CMD_EDIT,   2, 0, 32'hcafe_f00d, 16'h8000);
    // Removes at a bad position, a middle position, the tail and the head.
    send_command(CMD_RM_AT,   4, 0, '0, '0);
    send_command(CMD_RM_AT,   1, 0, '0, '0);
    send_command(CMD_RM_TAIL, 0, 0, '0, '0);
    send_command(CMD_RM_HEAD, 0, 0, '0, '0);
    send_command(CMD_SPARE_LO, 127, 127, 32'hffff_ffff, 16'hffff);
    send_command(CMD_SPARE_HI, 0, 0, '0, '0);
    drain_replies();

    // Random part: a balanced stretch, then one weighted to inserts, then one weighted to removes.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < 120) mix = MIX_BALANCED;
      else if (i < 300) mix = MIX_GROW;
      else mix = MIX_SHRINK;
      if (i == 240) drain_replies();
      cmd  = pick_command(mix);
      pos  = pick_position(cmd, shadow.fill);
      pos2 = ($urandom_range(0, 7) == 0) ? pos : pick_position(cmd, shadow.fill);
      send_command(cmd, pos, pos2, $urandom, 16'($urandom_range(0, 65535)));
    end

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
